// ===== hw/rtl/cu_pkg.sv =====
// Shared constants, types and codes for the combination unrank block.
package cu_pkg;

    localparam int MAX_SET_SIZE = 64;
    localparam int MAX_CHOOSE   = 16;

    localparam int RANK_W = 49;
    localparam int N_W    = 7;
    localparam int K_W    = 5;
    localparam int POS_W  = 6;
    localparam int SLOT_W = 4;
    localparam int CFG_W  = 7;

    // Binomial table: one row per top value, one column per bottom value minus one.
    localparam int ROW_W     = (MAX_SET_SIZE > 1) ? $clog2(MAX_SET_SIZE) : 1;
    localparam int COL_W     = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int TBL_DEPTH = 1 << ADDR_W;

    // The candidate can run below zero by up to the choose count.
    localparam int V_W = $clog2(MAX_SET_SIZE + MAX_CHOOSE + 1) + 1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [RANK_W-1:0] t_binom;

    typedef struct packed {
        logic   we;
        t_addr  waddr;
        t_binom wdata;
        t_addr  raddr;
    } t_tbl_req;

    typedef enum logic [0:0] {
        CFG_SET_SIZE     = 1'b0,
        CFG_CHOOSE_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } t_state;

endpackage

// ===== hw/rtl/combination_unrank.sv =====
// Top level of the combination unrank block: configuration, table fill, search and table RAM.
//
// A rank is transferred in on a cycle with start high and busy low. The block then
// emits one result per slot of the subset, k in all, each on o_position, o_slot and
// o_last for exactly one cycle with o_valid high; o_last marks slot k-1. The
// receiver cannot hold results off, so nothing waits on the output side.
// Each candidate position is tested with one read of the binomial table RAM. Busy
// falls in the cycle of the last result, so the next rank can be transferred in that
// cycle. Each result is registered from the compare of the candidate that fits. A
// choose count of zero gives no results and frees the block at once.
// After reset the binomial table is built row by row with busy high.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data) is
// always ready; index 0 writes the set size n, index 1 the choose count k. Both
// registers return to n = 8 and k = 2 at reset.
module combination_unrank
    import cu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [RANK_W-1:0] i_subset_rank,
    output logic              o_valid,
    output logic [POS_W-1:0]  o_position,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_last,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic [N_W-1:0] r_set_size;
    logic [K_W-1:0] r_choose_count;
    t_tbl_req       fill_req;
    logic           fill_done;
    t_binom         tbl_rdata;
    t_addr          search_raddr;
    t_addr          tbl_raddr;
    logic           search_active;
    logic           go;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size     <= N_W'(8);
            r_choose_count <= K_W'(2);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SET_SIZE:     r_set_size     <= i_cfg_data[N_W-1:0];
                CFG_CHOOSE_COUNT: r_choose_count <= i_cfg_data[K_W-1:0];
                default:          r_set_size     <= r_set_size;
            endcase
        end
    end

    assign busy = !fill_done || search_active;
    assign go   = start && !busy;

    cu_fill u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rdata (tbl_rdata),
        .o_req   (fill_req),
        .o_done  (fill_done)
    );

    cu_search u_search (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (go),
        .i_rank         (i_subset_rank),
        .i_set_size     (r_set_size),
        .i_choose_count (r_choose_count),
        .i_rdata        (tbl_rdata),
        .o_raddr        (search_raddr),
        .o_active       (search_active),
        .o_valid        (o_valid),
        .o_position     (o_position),
        .o_slot         (o_slot),
        .o_last         (o_last)
    );

    assign tbl_raddr = fill_done ? search_raddr : fill_req.raddr;

    cu_ram #(
        .WIDTH (RANK_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (fill_req.we),
        .i_waddr (fill_req.waddr),
        .i_wdata (fill_req.wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

endmodule

// ===== hw/rtl/cu_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module cu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/cu_fill.sv =====
// Sequencer that builds the binomial table row by row from the row above after reset.
module cu_fill
    import cu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_binom   i_rdata,
    output t_tbl_req o_req,
    output logic     o_done
);

    logic             r_run;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             r_wr_pend;
    logic [ROW_W-1:0] r_wr_row;
    logic [COL_W-1:0] r_wr_col;
    t_binom           r_left;
    logic             r_done;
    logic             last_entry;
    t_binom           left_term;

    assign last_entry = (r_row == ROW_W'(MAX_SET_SIZE - 1)) && (r_col == COL_W'(MAX_CHOOSE - 1));

    // The entry to the left in the row above is C(v-1, b-1); the first column adds C(v-1, 0).
    assign left_term = (r_wr_col == '0) ? RANK_W'(1) : r_left;

    always_comb begin
        o_req.raddr = {r_row - ROW_W'(1), r_col};
        o_req.we    = r_wr_pend;
        o_req.waddr = {r_wr_row, r_wr_col};
        o_req.wdata = (r_wr_row == '0) ? '0 : (i_rdata + left_term);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b1;
            r_row     <= '0;
            r_col     <= '0;
            r_wr_pend <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_wr_pend <= r_run;
            if (r_run) begin
                if (last_entry) begin
                    r_run <= 1'b0;
                end else if (r_col == COL_W'(MAX_CHOOSE - 1)) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            if (r_wr_pend && !r_run) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_row <= r_row;
        r_wr_col <= r_col;
        if (r_wr_pend) begin
            r_left <= i_rdata;
        end
    end

    assign o_done = r_done;

endmodule

// ===== hw/rtl/cu_search.sv =====
// Downward search over table candidates that emits one position per slot.
module cu_search
    import cu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [RANK_W-1:0] i_rank,
    input  logic [N_W-1:0]    i_set_size,
    input  logic [K_W-1:0]    i_choose_count,
    input  t_binom            i_rdata,
    output t_addr             o_raddr,
    output logic              o_active,
    output logic              o_valid,
    output logic [POS_W-1:0]  o_position,
    output logic [SLOT_W-1:0] o_slot,
    output logic              o_last
);

    t_state                   r_state, n_state;
    logic [RANK_W-1:0]        r_x;
    logic signed [V_W-1:0]    r_v;
    logic [K_W-1:0]           r_b;
    logic [SLOT_W-1:0]        r_c;
    logic [N_W-1:0]           r_n;
    logic                     r_valid;
    logic [POS_W-1:0]         r_pos;
    logic [SLOT_W-1:0]        r_slot;
    logic                     r_last;

    logic [N_W-1:0]           n_clamp;
    logic [K_W-1:0]           k_clamp;
    logic signed [V_W-1:0]    v_init;
    logic signed [V_W-1:0]    v_dec;
    logic [K_W-1:0]           b_m1;
    logic [K_W-1:0]           b_m2;
    logic [K_W-1:0]           k_m1;
    logic                     below;
    t_binom                   eff;
    logic                     fit;
    logic [V_W-1:0]           pos_full;

    assign n_clamp = (i_set_size > N_W'(MAX_SET_SIZE)) ? N_W'(MAX_SET_SIZE) : i_set_size;
    assign k_clamp = (i_choose_count > K_W'(MAX_CHOOSE)) ? K_W'(MAX_CHOOSE) : i_choose_count;

    assign v_init = $signed(V_W'(n_clamp)) - V_W'(1);
    assign v_dec  = r_v - V_W'(1);
    assign b_m1   = r_b - K_W'(1);
    assign b_m2   = r_b - K_W'(2);
    assign k_m1   = k_clamp - K_W'(1);

    // A candidate below the bottom value has a binomial of zero whatever the table holds.
    assign below = r_v < $signed(V_W'(r_b));
    assign eff   = below ? '0 : i_rdata;
    assign fit   = eff <= r_x;

    assign pos_full = V_W'(r_n) - V_W'(1) - $unsigned(r_v);

    // The next read is chosen from this compare so that a new slot starts without a bubble.
    always_comb begin
        unique case (r_state)
            ST_IDLE:   o_raddr = {v_init[ROW_W-1:0], k_m1[COL_W-1:0]};
            ST_SEARCH: o_raddr = {v_dec[ROW_W-1:0], fit ? b_m2[COL_W-1:0] : b_m1[COL_W-1:0]};
            default:   o_raddr = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_go && (k_clamp != '0)) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (fit && (r_b == K_W'(1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_SEARCH) && fit;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_go) begin
                    r_x <= i_rank;
                    r_v <= v_init;
                    r_b <= k_clamp;
                    r_c <= '0;
                    r_n <= n_clamp;
                end
            end
            ST_SEARCH: begin
                r_v <= v_dec;
                if (fit) begin
                    r_x    <= r_x - eff;
                    r_b    <= b_m1;
                    r_c    <= r_c + SLOT_W'(1);
                    r_pos  <= pos_full[POS_W-1:0];
                    r_slot <= r_c;
                    r_last <= (r_b == K_W'(1));
                end
            end
            default: begin
                r_v <= r_v;
            end
        endcase
    end

    assign o_active   = (r_state != ST_IDLE);
    assign o_valid    = r_valid;
    assign o_position = r_pos;
    assign o_slot     = r_slot;
    assign o_last     = r_last;

endmodule
